// ----- src/polygon_window_clipper_core_macros.svh -----
// Assertion macros for the polygon window clipper core.
// Included by the top level; relies on clk and arst_n in the including module.
`ifndef POLYGON_WINDOW_CLIPPER_CORE_MACROS_SVH
`define POLYGON_WINDOW_CLIPPER_CORE_MACROS_SVH

// Implication in the same cycle.
`define PWC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define PWC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pwc_pkg.sv -----
// Shared constants and types for the polygon window clipper core.
// No dependencies.
package pwc_pkg;

	localparam int MAX_VERTS_DEF = 32;
	localparam int COORD_W = 16;
	localparam int CFG_IDX_W = 8;

	localparam logic signed [COORD_W-1:0] WIN_MIN_RST = 16'sd0;
	localparam logic signed [COORD_W-1:0] WIN_MAX_RST = 16'sd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_MIN = 8'd0,
		REG_X_MAX = 8'd1,
		REG_Y_MIN = 8'd2,
		REG_Y_MAX = 8'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SIDE_BOTTOM = 2'd0,
		SIDE_RIGHT  = 2'd1,
		SIDE_TOP    = 2'd2,
		SIDE_LEFT   = 2'd3
	} side_t;

endpackage

// ----- src/polygon_window_clipper_core.sv -----
// Polygon window clipper: vertices load one per cycle, accepted while busy is low.
// After the last vertex, four Sutherland-Hodgman passes share one multiply/divide datapath:
// each pass opens by reading its first vertex, then walks every polygon edge: read, latch and
// decide, plus two multiply steps and a 35-step restoring divider on a crossing; then it closes.
// Survivors are read back and output; busy drops with the last result, which cannot be stalled.
// Reset (arst_n low, asynchronous) sets the window to 0..200, empties the store, clears overflow.
module polygon_window_clipper_core #(
	parameter int MAX_VERTS = pwc_pkg::MAX_VERTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [pwc_pkg::COORD_W-1:0]     vertex_x,
	input  logic signed [pwc_pkg::COORD_W-1:0]     vertex_y,
	input  logic                                   last_vertex,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic        [pwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic        [pwc_pkg::COORD_W-1:0]     cfg_data,
	output logic                                   out_valid,
	output logic signed [pwc_pkg::COORD_W-1:0]     out_x,
	output logic signed [pwc_pkg::COORD_W-1:0]     out_y,
	output logic                                   last_out,
	output logic                                   empty_polygon,
	output logic                                   overflow
);
	import pwc_pkg::*;

	`include "polygon_window_clipper_core_macros.svh"

	localparam int ADDR_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
	localparam int CNT_W  = $clog2(MAX_VERTS + 1);
	localparam int DW     = 17;           // differences of 16-bit coordinates
	localparam int PW     = 2 * DW;       // product width
	localparam int NW     = PW + 1;       // accumulated numerator width
	localparam int DCW    = $clog2(NW + 1);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_VERTS);

	// The sequencer walks each pass one polygon edge at a time.
	typedef enum logic [15:0] {
		S_IDLE  = 16'd1,
		S_FIRST = 16'd2,
		S_LOAD0 = 16'd4,
		S_RD    = 16'd8,
		S_LATCH = 16'd16,
		S_DEC   = 16'd32,
		S_MUL1  = 16'd64,
		S_MUL2  = 16'd128,
		S_DIVI  = 16'd256,
		S_DIV   = 16'd512,
		S_PUTI  = 16'd1024,
		S_PUTE  = 16'd2048,
		S_NEXT  = 16'd4096,
		S_PEND  = 16'd8192,
		S_ORD   = 16'd16384,
		S_OEM   = 16'd32768
	} state_t;

	state_t state_q;

	// Window registers.
	logic signed [COORD_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;

	// Vertex stores: each entry packs y in the upper half and x in the lower half.
	logic [2*COORD_W-1:0] mem_a [MAX_VERTS];
	logic [2*COORD_W-1:0] mem_b [MAX_VERTS];
	logic [2*COORD_W-1:0] rd_a_q, rd_b_q, rdata;

	logic [CNT_W-1:0] n_q, cnt_q, j_q;
	logic [1:0] side_q;
	logic ovf_q;
	logic wrap_q, e_in_q, last_q;
	logic [2*COORD_W-1:0] s_q, e_q, first_q;

	logic signed [NW-1:0] acc_q;
	logic [NW-1:0] quo_q;
	logic [DW:0] rem_q;
	logic neg_q;
	logic [DCW-1:0] div_cnt_q;

	logic out_valid_q, last_out_q, empty_q, ovf_out_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q;

	logic accept;
	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Memory write and read control.
	logic we_a, we_b, re;
	logic [ADDR_W-1:0] wa, ra;
	logic [2*COORD_W-1:0] wd;
	logic [CNT_W-1:0] j_nxt;
	logic side_odd;

	// Intersection operands, picked by the current window side.
	logic signed [COORD_W-1:0] sx, sy, ex, ey, a0, c0, a1, c1, bnd;
	logic signed [DW-1:0] den, d1, d2, mul_a, mul_b;
	logic signed [PW-1:0] prod;
	logic [DW-1:0] den_mag;
	logic [DW:0] rem_sh;
	logic rem_ge;
	logic [NW-1:0] q_signed;
	logic [COORD_W-1:0] q_res;
	logic [2*COORD_W-1:0] ipt;
	logic s_in, e_in;

	assign side_odd = side_q[0];
	assign j_nxt = j_q + CNT_W'(1);
	assign rdata = side_odd ? rd_b_q : rd_a_q;

	assign sx = s_q[COORD_W-1:0];
	assign sy = s_q[2*COORD_W-1:COORD_W];
	assign ex = e_q[COORD_W-1:0];
	assign ey = e_q[2*COORD_W-1:COORD_W];

	function automatic logic inside_win(input logic [1:0] side,
		input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
		input logic signed [COORD_W-1:0] xmn, input logic signed [COORD_W-1:0] xmx,
		input logic signed [COORD_W-1:0] ymn, input logic signed [COORD_W-1:0] ymx);
		logic r;
		case (side_t'(side))
			SIDE_BOTTOM: r = (y >= ymn);
			SIDE_RIGHT:  r = (x <= xmx);
			SIDE_TOP:    r = (y <= ymx);
			SIDE_LEFT:   r = (x >= xmn);
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

	assign s_in = inside_win(side_q, sx, sy, x_min_q, x_max_q, y_min_q, y_max_q);
	assign e_in = inside_win(side_q, ex, ey, x_min_q, x_max_q, y_min_q, y_max_q);

	always_comb begin
		case (side_t'(side_q))
			SIDE_BOTTOM: bnd = y_min_q;
			SIDE_RIGHT:  bnd = x_max_q;
			SIDE_TOP:    bnd = y_max_q;
			SIDE_LEFT:   bnd = x_min_q;
			default:     bnd = y_min_q;
		endcase
		// Horizontal edges solve for x along y, vertical edges solve for y along x.
		if (side_odd) begin
			a0 = sy; c0 = sx; a1 = ey; c1 = ex;
		end else begin
			a0 = sx; c0 = sy; a1 = ex; c1 = ey;
		end
	end

	assign den = DW'(c1) - DW'(c0);
	assign d1  = DW'(bnd) - DW'(c0);
	assign d2  = DW'(a1) - DW'(a0);
	assign mul_a = (state_q == S_MUL1) ? DW'(a0) : d1;
	assign mul_b = (state_q == S_MUL1) ? den : d2;
	assign prod = mul_a * mul_b;
	assign den_mag = den[DW-1] ? DW'(-den) : den;

	assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
	assign rem_ge = (rem_sh >= {1'b0, den_mag});
	assign q_signed = neg_q ? NW'(-quo_q) : quo_q;
	assign q_res = q_signed[COORD_W-1:0];
	assign ipt = side_odd ? {q_res, bnd} : {bnd, q_res};

	always_comb begin
		we_a = 1'b0;
		we_b = 1'b0;
		wa = cnt_q[ADDR_W-1:0];
		wd = e_q;
		re = 1'b0;
		ra = j_nxt[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				wa = n_q[ADDR_W-1:0];
				wd = {vertex_y, vertex_x};
				we_a = accept && (n_q < CAP);
			end
			S_FIRST: begin
				re = 1'b1;
				ra = '0;
			end
			S_RD: begin
				re = (j_nxt < n_q);
			end
			S_PUTI, S_PUTE: begin
				wd = (state_q == S_PUTI) ? ipt : e_q;
				we_a = side_odd && (cnt_q < CAP);
				we_b = !side_odd && (cnt_q < CAP);
			end
			S_ORD: begin
				re = 1'b1;
				ra = j_q[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wa] <= wd;
		end
		if (we_b) begin
			mem_b[wa] <= wd;
		end
		if (re) begin
			rd_a_q <= mem_a[ra];
			rd_b_q <= mem_b[ra];
		end
	end

	// Window configuration; writes to indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= WIN_MIN_RST;
			x_max_q <= WIN_MAX_RST;
			y_min_q <= WIN_MIN_RST;
			y_max_q <= WIN_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_X_MIN: x_min_q <= cfg_data;
				REG_X_MAX: x_max_q <= cfg_data;
				REG_Y_MIN: y_min_q <= cfg_data;
				REG_Y_MAX: y_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD0: begin
				s_q <= rdata;
				first_q <= rdata;
			end
			S_RD: wrap_q <= !(j_nxt < n_q);
			S_LATCH: e_q <= wrap_q ? first_q : rdata;
			S_DEC: begin
				e_in_q <= e_in;
			end
			S_MUL1: acc_q <= NW'(prod);
			S_MUL2: acc_q <= acc_q + NW'(prod);
			S_DIVI: begin
				neg_q <= acc_q[NW-1] ^ den[DW-1];
				quo_q <= acc_q[NW-1] ? NW'(-acc_q) : acc_q;
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_ge ? (rem_sh - {1'b0, den_mag}) : rem_sh;
				quo_q <= {quo_q[NW-2:0], rem_ge};
			end
			S_NEXT: s_q <= e_q;
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			cnt_q <= '0;
			j_q <= '0;
			side_q <= '0;
			ovf_q <= 1'b0;
			div_cnt_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
			last_out_q <= 1'b0;
			empty_q <= 1'b0;
			ovf_out_q <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
		end else begin
			out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (n_q < CAP) begin
							n_q <= n_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_vertex) begin
							side_q <= '0;
							cnt_q <= '0;
							state_q <= S_FIRST;
						end
					end
				end
				S_FIRST: begin
					j_q <= '0;
					state_q <= (n_q == '0) ? S_PEND : S_LOAD0;
				end
				S_LOAD0: state_q <= S_RD;
				S_RD:    state_q <= S_LATCH;
				S_LATCH: state_q <= S_DEC;
				S_DEC: begin
					if (s_in != e_in) begin
						state_q <= S_MUL1;
					end else if (s_in) begin
						state_q <= S_PUTE;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIVI;
				S_DIVI: begin
					div_cnt_q <= DCW'(NW);
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - DCW'(1);
					if (div_cnt_q == DCW'(1)) begin
						state_q <= S_PUTI;
					end
				end
				S_PUTI, S_PUTE: begin
					if (cnt_q < CAP) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					// An entering edge also keeps its end vertex after the crossing.
					state_q <= (state_q == S_PUTI && e_in_q) ? S_PUTE : S_NEXT;
				end
				S_NEXT: begin
					if (j_nxt == n_q) begin
						state_q <= S_PEND;
					end else begin
						j_q <= j_nxt;
						state_q <= S_RD;
					end
				end
				S_PEND: begin
					n_q <= cnt_q;
					cnt_q <= '0;
					side_q <= side_q + 2'd1;
					j_q <= '0;
					if (side_q == 2'(SIDE_LEFT)) begin
						if (cnt_q == '0) begin
							// Nothing survived: a single flagged item.
							out_valid_q <= 1'b1;
							out_x_q <= '0;
							out_y_q <= '0;
							last_out_q <= 1'b1;
							empty_q <= 1'b1;
							ovf_out_q <= ovf_q;
							n_q <= '0;
							ovf_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_ORD;
						end
					end else begin
						state_q <= S_FIRST;
					end
				end
				S_ORD: begin
					last_q <= (j_nxt == n_q);
					state_q <= S_OEM;
				end
				S_OEM: begin
					out_valid_q <= 1'b1;
					out_x_q <= rd_a_q[COORD_W-1:0];
					out_y_q <= rd_a_q[2*COORD_W-1:COORD_W];
					last_out_q <= last_q;
					empty_q <= 1'b0;
					ovf_out_q <= ovf_q;
					j_q <= j_nxt;
					if (last_q) begin
						n_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ORD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign last_out = last_out_q;
	assign empty_polygon = empty_q;
	assign overflow = ovf_out_q;

	`PWC_ASSERT_SAME(a_empty_is_last, out_valid && empty_polygon, last_out && out_x == '0 && out_y == '0, "empty item must be the last, at the origin")
	`PWC_ASSERT_NEXT(a_last_ends_burst, out_valid && last_out, !out_valid, "result after last item of a polygon")
	`PWC_ASSERT_NEXT(a_close_starts_clip, start && !busy && last_vertex, busy, "closing vertex did not start clipping")
	`PWC_ASSERT_SAME(a_no_out_in_load, out_valid, !(state_q == S_FIRST || state_q == S_DIV), "result during clipping passes")

endmodule

// ----- bench/polygon_window_clipper_checker.sv -----
`timescale 1ns / 1ps
// Checker for the polygon window clipper core: watches the vertex, register and result
// channels, predicts the clipped polygon and compares it with each result. Depends on pwc_pkg.
module polygon_window_clipper_checker #(
	parameter int MAX_VERTS = pwc_pkg::MAX_VERTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [pwc_pkg::COORD_W-1:0]  vertex_x,
	input  logic signed [pwc_pkg::COORD_W-1:0]  vertex_y,
	input  logic                                last_vertex,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [pwc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pwc_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                out_valid,
	input  logic signed [pwc_pkg::COORD_W-1:0]  out_x,
	input  logic signed [pwc_pkg::COORD_W-1:0]  out_y,
	input  logic                                last_out,
	input  logic                                empty_polygon,
	input  logic                                overflow,
	output int                                  fail_count,
	output int                                  pending
);
	import pwc_pkg::*;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
		logic                      empty;
		logic                      ovf;
	} clipped_vertex_t;

	logic signed [COORD_W-1:0] win_x_min, win_x_max, win_y_min, win_y_max;
	point_t          poly_in[$];
	point_t          poly_out[$];
	logic            dropped;
	clipped_vertex_t expected_vertices[$];

	assign pending = expected_vertices.size();

	function automatic logic on_inner_side(point_t p, side_t side);
		case (side)
			SIDE_BOTTOM: return p.y >= win_y_min;
			SIDE_RIGHT:  return p.x <= win_x_max;
			SIDE_TOP:    return p.y <= win_y_max;
			default:     return p.x >= win_x_min;
		endcase
	endfunction

	// Coordinate a at the crossing of line (a0,c0)-(a1,c1) with c = b, truncated toward zero.
	function automatic logic signed [COORD_W-1:0] cross_coord(longint a0, longint c0,
			longint a1, longint c1, longint b);
		longint den, num, q;
		den = c1 - c0;
		num = a0 * den + (b - c0) * (a1 - a0);
		q = num / den;
		return q[COORD_W-1:0];
	endfunction

	function automatic point_t edge_crossing(point_t s, point_t e, side_t side);
		point_t p;
		case (side)
			SIDE_BOTTOM: begin
				p.x = cross_coord(s.x, s.y, e.x, e.y, win_y_min);
				p.y = win_y_min;
			end
			SIDE_RIGHT: begin
				p.x = win_x_max;
				p.y = cross_coord(s.y, s.x, e.y, e.x, win_x_max);
			end
			SIDE_TOP: begin
				p.x = cross_coord(s.x, s.y, e.x, e.y, win_y_max);
				p.y = win_y_max;
			end
			default: begin
				p.x = win_x_min;
				p.y = cross_coord(s.y, s.x, e.y, e.x, win_x_min);
			end
		endcase
		return p;
	endfunction

	function automatic void keep_vertex(point_t p);
		if (poly_out.size() < MAX_VERTS)
			poly_out.push_back(p);
		else
			dropped = 1'b1;
	endfunction

	// One Sutherland-Hodgman pass: poly_in is replaced by its part on the inner side.
	function automatic void clip_against(side_t side);
		point_t s, e;
		logic   s_in, e_in;
		int     n;
		n = poly_in.size();
		poly_out.delete();
		for (int j = 0; j < n; j++) begin
			s = poly_in[j];
			e = poly_in[(j + 1 < n) ? j + 1 : 0];
			s_in = on_inner_side(s, side);
			e_in = on_inner_side(e, side);
			if (s_in && e_in) begin
				keep_vertex(e);
			end else if (s_in) begin
				keep_vertex(edge_crossing(s, e, side));
			end else if (e_in) begin
				keep_vertex(edge_crossing(s, e, side));
				keep_vertex(e);
			end
		end
		poly_in = poly_out;
	endfunction

	function automatic void predict_clipped_polygon();
		clipped_vertex_t r;
		clip_against(SIDE_BOTTOM);
		clip_against(SIDE_RIGHT);
		clip_against(SIDE_TOP);
		clip_against(SIDE_LEFT);
		if (poly_in.size() == 0) begin
			r = '{x: '0, y: '0, last: 1'b1, empty: 1'b1, ovf: dropped};
			expected_vertices.push_back(r);
		end else begin
			foreach (poly_in[k]) begin
				r = '{x: poly_in[k].x, y: poly_in[k].y, last: (k == poly_in.size() - 1),
					empty: 1'b0, ovf: dropped};
				expected_vertices.push_back(r);
			end
		end
		poly_in.delete();
		dropped = 1'b0;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: mismatch: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		clipped_vertex_t want;
		point_t          p;
		if (!arst_n) begin
			win_x_min = WIN_MIN_RST;
			win_x_max = WIN_MAX_RST;
			win_y_min = WIN_MIN_RST;
			win_y_max = WIN_MAX_RST;
			poly_in.delete();
			expected_vertices.delete();
			dropped = 1'b0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_MIN: win_x_min = cfg_data;
					REG_X_MAX: win_x_max = cfg_data;
					REG_Y_MIN: win_y_min = cfg_data;
					REG_Y_MAX: win_y_max = cfg_data;
					default: ;
				endcase
			end
			if (out_valid) begin
				if (expected_vertices.size() == 0) begin
					report_mismatch($sformatf("unexpected result (%0d,%0d)", out_x, out_y));
				end else begin
					want = expected_vertices.pop_front();
					if (out_x !== want.x || out_y !== want.y || last_out !== want.last ||
						empty_polygon !== want.empty || overflow !== want.ovf)
						report_mismatch($sformatf(
							"got (%0d,%0d) last %b empty %b ovf %b, want (%0d,%0d) %b %b %b",
							out_x, out_y, last_out, empty_polygon, overflow,
							want.x, want.y, want.last, want.empty, want.ovf));
				end
			end
			// Vertex transaction: stored, or dropped once the store is full.
			if (start && !busy) begin
				p.x = vertex_x;
				p.y = vertex_y;
				if (poly_in.size() < MAX_VERTS)
					poly_in.push_back(p);
				else
					dropped = 1'b1;
				if (last_vertex)
					predict_clipped_polygon();
			end
		end
	end

endmodule

// ----- bench/polygon_window_clipper_core_tb.sv -----
`timescale 1ns / 1ps
// Top of the polygon window clipper testbench: clock, reset, vertex and register stimulus,
// watchdog and verdict. Depends on pwc_pkg, polygon_window_clipper_core and the checker.
module polygon_window_clipper_core_tb;
	import pwc_pkg::*;

	// Longest quiet stretch allowed: many times a full clip of a 32-vertex polygon with crossings
	// on every edge of every pass.
	localparam int QUIET_LIMIT = 100000;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic signed [COORD_W-1:0]  vertex_x;
	logic signed [COORD_W-1:0]  vertex_y;
	logic                       last_vertex;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [COORD_W-1:0]         cfg_data;
	logic                       out_valid;
	logic signed [COORD_W-1:0]  out_x;
	logic signed [COORD_W-1:0]  out_y;
	logic                       last_out;
	logic                       empty_polygon;
	logic                       overflow;
	int                         fail_count;
	int                         pending;
	int                         quiet_cycles;

	// Window as the stimulus sees it, used to aim random vertices near the edges.
	int win_lo_x, win_hi_x, win_lo_y, win_hi_y;
	// When set, the sender never pauses between vertices.
	logic back_to_back;

	polygon_window_clipper_core DUT (.*);

	polygon_window_clipper_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: any transaction on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic idle_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// Send one vertex; start stays high into the next vertex when no gap follows.
	task automatic send_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic is_last);
		int gap;
		gap = back_to_back ? 0 : $urandom_range(0, 13);
		start       <= 1'b1;
		vertex_x    <= x;
		vertex_y    <= y;
		last_vertex <= is_last;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			idle_cycles(gap);
		end
	endtask

	// Register writes happen only with nothing in flight and the clipping passes finished.
	task automatic write_window_reg(reg_idx_t idx, logic [COORD_W-1:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		idle_cycles(20);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(int x_lo, int x_hi, int y_lo, int y_hi);
		write_window_reg(REG_X_MIN, x_lo[COORD_W-1:0]);
		write_window_reg(REG_X_MAX, x_hi[COORD_W-1:0]);
		write_window_reg(REG_Y_MIN, y_lo[COORD_W-1:0]);
		write_window_reg(REG_Y_MAX, y_hi[COORD_W-1:0]);
		win_lo_x = x_lo;
		win_hi_x = x_hi;
		win_lo_y = y_lo;
		win_hi_y = y_hi;
	endtask

	// A coordinate mostly around the window, sometimes anywhere or at the extremes.
	function automatic logic signed [COORD_W-1:0] pick_coord(int lo, int hi);
		int sel, span, v;
		sel  = $urandom_range(0, 99);
		span = (hi > lo) ? hi - lo : lo - hi;
		if (span > 4000) span = 4000;
		if (sel < 60) begin
			v = lo - span / 2 + $signed($urandom_range(0, 2 * span + 4));
		end else if (sel < 75) begin
			v = (($urandom_range(0, 1) != 0) ? lo : hi) + $signed($urandom_range(0, 4)) - 2;
		end else if (sel < 92) begin
			v = $signed($urandom_range(0, 65535)) - 32768;
		end else begin
			v = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
		end
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[COORD_W-1:0];
	endfunction

	// Polygon with random vertices; mostly small, now and then beyond the store's capacity.
	task automatic send_random_polygon(ref int items);
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
		back_to_back = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < n; k++)
			send_vertex(pick_coord(win_lo_x, win_hi_x), pick_coord(win_lo_y, win_hi_y),
				k == n - 1);
		items += n;
	endtask

	initial begin
		int items;
		arst_n       = 1'b0;
		start        = 1'b0;
		vertex_x     = '0;
		vertex_y     = '0;
		last_vertex  = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		back_to_back = 1'b0;
		win_lo_x = 0;
		win_hi_x = 200;
		win_lo_y = 0;
		win_hi_y = 200;
		items = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset window of 0..200.
		// A lone inside vertex yields itself; a lone outside vertex yields the empty item.
		send_vertex(16'sd50, 16'sd60, 1'b1);
		send_vertex(-16'sd5, 16'sd60, 1'b1);
		// Triangle fully inside.
		send_vertex(16'sd10, 16'sd10, 1'b0);
		send_vertex(16'sd190, 16'sd20, 1'b0);
		send_vertex(16'sd100, 16'sd180, 1'b1);
		// Square around the window: all four of its edges lie outside, so every pass cuts
		// and the window's corners survive.
		back_to_back = 1'b1;
		send_vertex(-16'sd50, -16'sd50, 1'b0);
		send_vertex(16'sd250, -16'sd50, 1'b0);
		send_vertex(16'sd250, 16'sd250, 1'b0);
		send_vertex(-16'sd50, 16'sd250, 1'b1);
		// Diamond crossing all four window edges, with truncation on odd slopes.
		send_vertex(16'sd100, -16'sd33, 1'b0);
		send_vertex(16'sd237, 16'sd100, 1'b0);
		send_vertex(16'sd100, 16'sd241, 1'b0);
		send_vertex(-16'sd37, 16'sd100, 1'b1);
		back_to_back = 1'b0;
		// Extremes of both coordinates.
		send_vertex(-16'sd32768, -16'sd32768, 1'b0);
		send_vertex(16'sd32767, -16'sd32768, 1'b0);
		send_vertex(16'sd32767, 16'sd32767, 1'b0);
		send_vertex(-16'sd32768, 16'sd32767, 1'b1);
		// Repeated vertex, and an edge lying on a window boundary.
		send_vertex(16'sd200, 16'sd0, 1'b0);
		send_vertex(16'sd200, 16'sd0, 1'b1);
		send_vertex(16'sd0, 16'sd0, 1'b0);
		send_vertex(16'sd200, 16'sd0, 1'b0);
		send_vertex(16'sd300, 16'sd300, 1'b1);
		items = 22;

		// Random part, phase by phase: the reset window, a tiny one, the full coordinate range,
		// an inverted one, a negative one, a write to an unused index, then random windows.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: ;
				1: set_window(10, 13, -7, -2);
				2: set_window(-32768, 32767, -32768, 32767);
				3: set_window(150, 50, 0, 200);
				4: set_window(-1000, -200, -32768, -30000);
				5: begin
					// An index past the last register must leave the window alone.
					write_window_reg(reg_idx_t'(8'd4 + 8'($urandom_range(0, 251))),
						16'($urandom_range(0, 65535)));
				end
				default: begin
					int a, b;
					a = $signed(16'($urandom_range(0, 65535)));
					b = a + $urandom_range(0, 3000);
					if (b > 32767) b = 32767;
					set_window(a, b, a - $urandom_range(0, 500), b - $urandom_range(0, 500));
				end
			endcase
			while (items < 22 + 44 * (phase + 1))
				send_random_polygon(items);
		end

		start <= 1'b0;
		@(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		idle_cycles(50);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
